@@ hw/rtl/slt_pkg.sv @@
// ============================================================================
// slt_pkg
// Shared types, token kinds and character classes for the tokenizer.
// ============================================================================
package slt_pkg;

    typedef logic [1:0] token_kind_t;
    typedef logic [7:0] char_t;

    localparam token_kind_t KIND_NUMBER = 2'd0;
    localparam token_kind_t KIND_WORD   = 2'd1;
    localparam token_kind_t KIND_END    = 2'd2;

    localparam char_t CH_TAB       = 8'h09;
    localparam char_t CH_NEWLINE   = 8'h0A;
    localparam char_t CH_CR        = 8'h0D;
    localparam char_t CH_SPACE     = 8'h20;
    localparam char_t CH_LPAREN    = 8'h28;
    localparam char_t CH_RPAREN    = 8'h29;
    localparam char_t CH_MINUS     = 8'h2D;
    localparam char_t CH_ZERO      = 8'h30;
    localparam char_t CH_NINE      = 8'h39;
    localparam char_t CH_BACKSLASH = 8'h5C;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input char_t b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_digit(input char_t b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic ends_word(input char_t b);
        return is_space(b) || (b == CH_LPAREN) || (b == CH_BACKSLASH);
    endfunction

endpackage

@@ hw/rtl/slt_if.sv @@
// ============================================================================
// slt_if
// Valid/ready channels: source text bytes in, token descriptors out.
// ============================================================================
interface slt_byte_if
    import slt_pkg::*;
();
    logic  valid;
    logic  ready;
    char_t text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface slt_token_if
    import slt_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int OFFSET_BITS   = 24,
    parameter int LENGTH_BITS   = 12
)();
    logic                     valid;
    logic                     ready;
    token_kind_t              token_kind;
    logic [POSITION_BITS-1:0] start_line;
    logic [POSITION_BITS-1:0] start_column;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [LENGTH_BITS-1:0]   token_length;
    logic                     last_of_run;

    modport source (output valid, output token_kind, output start_line,
                    output start_column, output start_offset, output token_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_line,
                    input start_column, input start_offset, input token_length,
                    input last_of_run, output ready);
endinterface

@@ hw/rtl/slt_scan.sv @@
// ============================================================================
// slt_scan
// Scanner state and per-byte decision logic; yields up to two results.
// ============================================================================
module slt_scan
    import slt_pkg::*;
#(
    parameter int DEPTH_BITS    = 8,
    parameter int POSITION_BITS = 16,
    parameter int OFFSET_BITS   = 24,
    parameter int LENGTH_BITS   = 12,
    localparam int ENTRY_BITS   = 2 + 2 * POSITION_BITS + OFFSET_BITS + LENGTH_BITS + 1
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  char_t                 text_byte,
    input  logic                  end_of_text,
    output logic [1:0]            push_count,
    output logic [ENTRY_BITS-1:0] entry0,
    output logic [ENTRY_BITS-1:0] entry1
);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_LINE   = 3'd1;
    localparam logic [2:0] MODE_PAREN  = 3'd2;
    localparam logic [2:0] MODE_MINUS  = 3'd3;
    localparam logic [2:0] MODE_NUMBER = 3'd4;
    localparam logic [2:0] MODE_WORD   = 3'd5;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef struct packed {
        token_kind_t              kind;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
        logic [OFFSET_BITS-1:0]   offset;
        logic [LENGTH_BITS-1:0]   length;
        logic                     last;
    } entry_t;

    logic [2:0]               mode_reg,   mode_next;
    logic [DEPTH_BITS-1:0]    depth_reg,  depth_next;
    logic [POSITION_BITS-1:0] line_reg,   line_next;
    logic [POSITION_BITS-1:0] col_reg,    col_next;
    logic [OFFSET_BITS-1:0]   off_reg,    off_next;
    logic [POSITION_BITS-1:0] tline_reg,  tline_next;
    logic [POSITION_BITS-1:0] tcol_reg,   tcol_next;
    logic [OFFSET_BITS-1:0]   toff_reg,   toff_next;
    logic [LENGTH_BITS-1:0]   tlen_reg,   tlen_next;

    logic [POSITION_BITS-1:0] line_inc, col_inc;
    logic [LENGTH_BITS-1:0]   tlen_inc;
    logic [DEPTH_BITS-1:0]    depth_inc;
    entry_t                   tok_ent, end_ent, r0, r1;
    logic                     do_decide;

    // saturating counters
    assign line_inc  = (line_reg  == '1) ? line_reg  : line_reg  + 1'b1;
    assign col_inc   = (col_reg   == '1) ? col_reg   : col_reg   + 1'b1;
    assign tlen_inc  = (tlen_reg  == '1) ? tlen_reg  : tlen_reg  + 1'b1;
    assign depth_inc = (depth_reg == '1) ? depth_reg : depth_reg + 1'b1;

    always_comb
    begin
        tok_ent.kind   = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_WORD;
        tok_ent.line   = tline_reg;
        tok_ent.column = tcol_reg;
        tok_ent.offset = toff_reg;
        tok_ent.length = tlen_reg;
        tok_ent.last   = 1'b1;

        end_ent.kind   = KIND_END;
        end_ent.line   = line_reg;
        end_ent.column = col_reg;
        end_ent.offset = off_reg;
        end_ent.length = '0;
        end_ent.last   = 1'b1;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        toff_next  = toff_reg;
        tlen_next  = tlen_reg;
        push_count = 2'd0;
        r0         = tok_ent;
        r1         = end_ent;
        do_decide  = 1'b0;

        if (accept)
        begin
            if (end_of_text)
            begin
                if ((mode_reg == MODE_NUMBER) || (mode_reg == MODE_WORD) ||
                    (mode_reg == MODE_MINUS))
                begin
                    r0.last    = 1'b0;
                    push_count = 2'd2;
                end
                else
                begin
                    r0         = end_ent;
                    push_count = 2'd1;
                end
                mode_next  = MODE_IDLE;
                depth_next = '0;
            end
            else
            begin
                off_next = off_reg + 1'b1;
                unique case (mode_reg)
                    MODE_LINE:
                    begin
                        if (text_byte == CH_NEWLINE)
                        begin
                            line_next = line_inc;
                            col_next  = POS_ONE;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_PAREN:
                    begin
                        if (text_byte == CH_LPAREN)
                            depth_next = depth_inc;
                        else if ((text_byte == CH_RPAREN) && (depth_reg != '0))
                            depth_next = depth_reg - 1'b1;
                        if (text_byte == CH_NEWLINE)
                        begin
                            line_next = line_inc;
                            col_next  = POS_ONE;
                        end
                        else
                            col_next = col_inc;
                        if (depth_next == '0)
                            mode_next = MODE_IDLE;
                    end
                    MODE_MINUS:
                    begin
                        if (is_digit(text_byte))
                        begin
                            tlen_next = tlen_inc;
                            col_next  = col_inc;
                            mode_next = MODE_NUMBER;
                        end
                        else if (ends_word(text_byte))
                        begin
                            push_count = 2'd1;
                            do_decide  = 1'b1;
                        end
                        else
                        begin
                            tlen_next = tlen_inc;
                            col_next  = col_inc;
                            mode_next = MODE_WORD;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(text_byte))
                        begin
                            tlen_next = tlen_inc;
                            col_next  = col_inc;
                        end
                        else
                        begin
                            push_count = 2'd1;
                            do_decide  = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (ends_word(text_byte))
                        begin
                            push_count = 2'd1;
                            do_decide  = 1'b1;
                        end
                        else
                        begin
                            tlen_next = tlen_inc;
                            col_next  = col_inc;
                        end
                    end
                    default:
                        do_decide = 1'b1;
                endcase

                // between-token handling; closing a token leaves line/column as is
                if (do_decide)
                begin
                    if (is_space(text_byte))
                    begin
                        if (text_byte == CH_NEWLINE)
                        begin
                            line_next = line_inc;
                            col_next  = POS_ONE;
                        end
                        else
                            col_next = col_inc;
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte == CH_BACKSLASH)
                        mode_next = MODE_LINE;
                    else if (text_byte == CH_LPAREN)
                    begin
                        col_next   = col_inc;
                        depth_next = DEPTH_BITS'(1);
                        mode_next  = MODE_PAREN;
                    end
                    else
                    begin
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        toff_next  = off_reg;
                        tlen_next  = LENGTH_BITS'(1);
                        col_next   = col_inc;
                        if (is_digit(text_byte))
                            mode_next = MODE_NUMBER;
                        else if (text_byte == CH_MINUS)
                            mode_next = MODE_MINUS;
                        else
                            mode_next = MODE_WORD;
                    end
                end
            end
        end
    end

    assign entry0 = r0;
    assign entry1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            off_reg   <= '0;
            tline_reg <= POS_ONE;
            tcol_reg  <= POS_ONE;
            toff_reg  <= '0;
            tlen_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            toff_reg  <= toff_next;
            tlen_reg  <= tlen_next;
        end
    end

endmodule

@@ hw/rtl/slt_fifo.sv @@
// ============================================================================
// slt_fifo
// Four-entry result queue, up to two writes and one read per cycle.
// ============================================================================
module slt_fifo
    import slt_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  logic [WIDTH-1:0] push_data0,
    input  logic [WIDTH-1:0] push_data1,
    output logic             room,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int FIFO_DEPTH = 4;

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg,  count_next;
    logic             pop;

    assign room      = count_reg <= 3'(FIFO_DEPTH - 2);
    assign pop_valid = count_reg != 3'd0;
    assign pop_data  = mem[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    assign wr_ptr_next = wr_ptr_reg + push_count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_count} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push_data0;
        if (push_count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push_data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/stack_language_tokenizer_unit.sv @@
// ============================================================================
// stack_language_tokenizer_unit
// Byte-stream tokenizer for a stack language: skips whitespace and comments,
// tracks line/column, emits number, word and end-of-text token descriptors.
// ============================================================================
// Throughput: one byte per cycle; an end-of-text transaction yields two
// descriptors when a token is open. A descriptor enters the result queue
// when its closing byte is accepted. Input stalls while the four-entry
// result queue has fewer than two free slots. Reset (rst_n, async, low)
// clears scanner state to line 1, column 1, offset 0 and empties the queue.
module stack_language_tokenizer_unit
    import slt_pkg::*;
#(
    parameter int DEPTH_BITS    = 8,
    parameter int POSITION_BITS = 16,
    parameter int OFFSET_BITS   = 24,
    parameter int LENGTH_BITS   = 12
)(
    input  logic         clk,
    input  logic         rst_n,
    slt_byte_if.sink     text_in,
    slt_token_if.source  token_out
);

    localparam int ENTRY_BITS = 2 + 2 * POSITION_BITS + OFFSET_BITS + LENGTH_BITS + 1;

    // must match the entry layout inside the scanner
    typedef struct packed {
        token_kind_t              kind;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
        logic [OFFSET_BITS-1:0]   offset;
        logic [LENGTH_BITS-1:0]   length;
        logic                     last;
    } entry_t;

    logic                  room;
    logic                  accept;
    logic [1:0]            push_count;
    logic [ENTRY_BITS-1:0] entry0, entry1;
    entry_t                head;

    // A transaction may push two descriptors, so accept only with two free
    // slots. Queue occupancy is registered, so ready does not depend on the
    // downstream ready in the same cycle.
    assign text_in.ready = room;
    assign accept        = text_in.valid && room;

    slt_scan #(
        .DEPTH_BITS    (DEPTH_BITS),
        .POSITION_BITS (POSITION_BITS),
        .OFFSET_BITS   (OFFSET_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_in.text_byte),
        .end_of_text (text_in.end_of_text),
        .push_count  (push_count),
        .entry0      (entry0),
        .entry1      (entry1)
    );

    // Result queue doubles as the output register stage.
    slt_fifo #(
        .WIDTH (ENTRY_BITS)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data0 (entry0),
        .push_data1 (entry1),
        .room       (room),
        .pop_valid  (token_out.valid),
        .pop_ready  (token_out.ready),
        .pop_data   (head)
    );

    assign token_out.token_kind   = head.kind;
    assign token_out.start_line   = head.line;
    assign token_out.start_column = head.column;
    assign token_out.start_offset = head.offset;
    assign token_out.token_length = head.length;
    assign token_out.last_of_run  = head.last;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for stack_language_tokenizer_unit. Feeds source text
// one byte per transaction, predicts every token descriptor in a scanner
// model of its own, and compares each accepted descriptor field by field.
// ============================================================================
module testbench;
    import slt_pkg::*;

    localparam int DEPTH_W       = 8;
    localparam int POS_W         = 16;
    localparam int OFF_W         = 24;
    localparam int LEN_W         = 12;
    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 8;        // idle wait after the last owed descriptor is taken
    localparam int CYCLE_LIMIT   = 1000000;  // watchdog bound on the whole run

    // whitespace codes the package does not name
    localparam char_t CH_VTAB = 8'h0B;
    localparam char_t CH_FEED = 8'h0C;

    // scanner modes of the predictor
    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_LINE_COMMENT,
        LEX_PAREN_COMMENT,
        LEX_MINUS,
        LEX_NUMBER,
        LEX_WORD
    } lex_mode_e;

    // what a byte means to the scanner
    typedef enum logic [2:0] {
        CLS_NEWLINE,
        CLS_BLANK,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_BACKSLASH,
        CLS_OTHER
    } char_class_e;

    typedef struct packed {
        token_kind_t        kind;
        logic [POS_W-1:0]   line;
        logic [POS_W-1:0]   column;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic               last;
    } token_desc_t;

    logic clk;
    logic rst_n;

    slt_byte_if text_if();
    slt_token_if #(
        .POSITION_BITS (POS_W),
        .OFFSET_BITS   (OFF_W),
        .LENGTH_BITS   (LEN_W)
    ) tok_if();

    stack_language_tokenizer_unit #(
        .DEPTH_BITS    (DEPTH_W),
        .POSITION_BITS (POS_W),
        .OFFSET_BITS   (OFF_W),
        .LENGTH_BITS   (LEN_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if.sink),
        .token_out (tok_if.source)
    );

    // descriptors still owed by the block, oldest first
    token_desc_t expected_tokens[$];
    // descriptors produced by the byte being predicted
    token_desc_t step_tokens[$];

    // predictor scanner state
    lex_mode_e          lex_mode;
    logic [DEPTH_W-1:0] paren_depth;
    logic [POS_W-1:0]   cur_line;
    logic [POS_W-1:0]   cur_column;
    logic [OFF_W-1:0]   cur_offset;
    logic [POS_W-1:0]   tok_line;
    logic [POS_W-1:0]   tok_column;
    logic [OFF_W-1:0]   tok_offset;
    logic [LEN_W-1:0]   tok_length;

    // idle limits for sender gaps and receiver stalls, redrawn per phase
    int gap_max;
    int stall_max;
    int items_sent;
    int mismatch_count;
    int cycle_count;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stack_language_tokenizer_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Scanner predictor
    // ------------------------------------------------------------------------
    function automatic char_class_e classify(input char_t b);
        if (b == CH_NEWLINE)
            return CLS_NEWLINE;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
            return CLS_BLANK;
        if (b >= CH_ZERO && b <= CH_NINE)
            return CLS_DIGIT;
        case (b)
            CH_MINUS:     return CLS_MINUS;
            CH_LPAREN:    return CLS_LPAREN;
            CH_RPAREN:    return CLS_RPAREN;
            CH_BACKSLASH: return CLS_BACKSLASH;
            default:      return CLS_OTHER;
        endcase
    endfunction

    // bytes that end a word: any whitespace, '(' or backslash
    function automatic logic is_delimiter(input char_class_e cls);
        return cls == CLS_NEWLINE || cls == CLS_BLANK || cls == CLS_LPAREN
            || cls == CLS_BACKSLASH;
    endfunction

    function automatic void bump_column();
        if (cur_column != '1)
            cur_column = cur_column + 1'b1;
    endfunction

    function automatic void next_line();
        if (cur_line != '1)
            cur_line = cur_line + 1'b1;
        cur_column = POS_W'(1);
    endfunction

    function automatic void open_token(input lex_mode_e mode);
        tok_line   = cur_line;
        tok_column = cur_column;
        tok_offset = cur_offset;
        tok_length = LEN_W'(1);
        bump_column();
        lex_mode = mode;
    endfunction

    function automatic void grow_token();
        if (tok_length != '1)
            tok_length = tok_length + 1'b1;
        bump_column();
    endfunction

    function automatic void close_token(input token_kind_t kind);
        token_desc_t desc;
        desc = '{kind, tok_line, tok_column, tok_offset, tok_length, 1'b0};
        step_tokens.insert(step_tokens.size(), desc);
        lex_mode = LEX_IDLE;
    endfunction

    // byte seen between tokens
    function automatic void dispatch_byte(input char_class_e cls);
        case (cls)
            CLS_NEWLINE:
            begin
                next_line();
                lex_mode = LEX_IDLE;
            end
            CLS_BLANK:
            begin
                bump_column();
                lex_mode = LEX_IDLE;
            end
            CLS_BACKSLASH: lex_mode = LEX_LINE_COMMENT;
            CLS_LPAREN:
            begin
                bump_column();
                paren_depth = DEPTH_W'(1);
                lex_mode = LEX_PAREN_COMMENT;
            end
            CLS_DIGIT:     open_token(LEX_NUMBER);
            CLS_MINUS:     open_token(LEX_MINUS);
            default:       open_token(LEX_WORD);
        endcase
    endfunction

    function automatic void predict_tokens(input char_t b, input logic eot);
        char_class_e cls;
        token_desc_t tail;
        token_desc_t end_desc;
        cls = classify(b);
        step_tokens.delete();
        if (eot)
        begin
            // flush the open token, then the end marker; open comments vanish
            if (lex_mode == LEX_NUMBER)
                close_token(KIND_NUMBER);
            else if (lex_mode == LEX_WORD || lex_mode == LEX_MINUS)
                close_token(KIND_WORD);
            end_desc = '{KIND_END, cur_line, cur_column, cur_offset, '0, 1'b0};
            step_tokens.insert(step_tokens.size(), end_desc);
            lex_mode    = LEX_IDLE;
            paren_depth = '0;
        end
        else
        begin
            case (lex_mode)
                LEX_LINE_COMMENT:
                begin
                    // column stands still inside a backslash comment
                    if (cls == CLS_NEWLINE)
                    begin
                        next_line();
                        lex_mode = LEX_IDLE;
                    end
                end
                LEX_PAREN_COMMENT:
                begin
                    if (cls == CLS_LPAREN)
                    begin
                        if (paren_depth != '1)
                            paren_depth = paren_depth + 1'b1;
                    end
                    else if (cls == CLS_RPAREN && paren_depth != 0)
                        paren_depth = paren_depth - 1'b1;
                    if (cls == CLS_NEWLINE)
                        next_line();
                    else
                        bump_column();
                    if (paren_depth == 0)
                        lex_mode = LEX_IDLE;
                end
                LEX_MINUS:
                begin
                    // the byte after a lone minus decides its fate
                    if (cls == CLS_DIGIT)
                    begin
                        grow_token();
                        lex_mode = LEX_NUMBER;
                    end
                    else if (is_delimiter(cls))
                    begin
                        close_token(KIND_WORD);
                        dispatch_byte(cls);
                    end
                    else
                    begin
                        grow_token();
                        lex_mode = LEX_WORD;
                    end
                end
                LEX_NUMBER:
                begin
                    if (cls == CLS_DIGIT)
                        grow_token();
                    else
                    begin
                        close_token(KIND_NUMBER);
                        dispatch_byte(cls);
                    end
                end
                LEX_WORD:
                begin
                    if (is_delimiter(cls))
                    begin
                        close_token(KIND_WORD);
                        dispatch_byte(cls);
                    end
                    else
                        grow_token();
                end
                default: dispatch_byte(cls);
            endcase
            cur_offset = cur_offset + 1'b1;
        end
        if (step_tokens.size() != 0)
        begin
            tail = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.insert(step_tokens.size(), tail);
        end
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transaction per byte, random gap before each
    // ------------------------------------------------------------------------
    task automatic send_byte(input char_t b, input logic eot);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= eot;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        predict_tokens(b, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_run(input char_t b, input int count);
        repeat (count) send_byte(b, 1'b0);
    endtask

    // byte lane carries junk on an end-of-text transaction
    task automatic send_end();
        send_byte(char_t'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the input off until every owed descriptor has been taken
    task automatic wait_for_drain();
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall before each descriptor
    // ------------------------------------------------------------------------
    initial
    begin : token_sink
        int stall;
        tok_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            @(posedge clk);
            while (!tok_if.valid)
                @(posedge clk);
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // every accepted descriptor is matched against the oldest expectation
    always @(posedge clk)
    begin : token_check
        token_desc_t want;
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("descriptor with none owed: kind %0d, offset %0d",
                       tok_if.token_kind, tok_if.start_offset);
                mismatch_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                compare_field("token_kind",   32'(want.kind),   32'(tok_if.token_kind));
                compare_field("start_line",   32'(want.line),   32'(tok_if.start_line));
                compare_field("start_column", 32'(want.column), 32'(tok_if.start_column));
                compare_field("start_offset", 32'(want.offset), 32'(tok_if.start_offset));
                compare_field("token_length", 32'(want.length), 32'(tok_if.token_length));
                compare_field("last_of_run",  32'(want.last),   32'(tok_if.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random text generators
    // ------------------------------------------------------------------------
    function automatic char_t blank_char();
        case ($urandom_range(0, 7))
            0:       return CH_TAB;
            1:       return CH_NEWLINE;
            2:       return CH_VTAB;
            3:       return CH_FEED;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // any byte that stays inside a word; the first one must start a word
    function automatic char_t word_char(input logic first);
        char_t       b;
        char_class_e cls;
        do
        begin
            b   = char_t'($urandom_range(0, 255));
            cls = classify(b);
        end
        while (is_delimiter(cls) || (first && (cls == CLS_DIGIT || cls == CLS_MINUS)));
        return b;
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 11;
        endcase
    endfunction

    // whitespace after a token most of the time; otherwise it runs into the next one
    task automatic send_delimiter();
        if ($urandom_range(0, 99) < 85)
            send_byte(blank_char(), 1'b0);
    endtask

    task automatic send_random_segment();
        int    pick;
        int    count;
        int    depth;
        char_t b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            // number, maybe negative
            if ($urandom_range(0, 1))
                send_byte(CH_MINUS, 1'b0);
            count = $urandom_range(1, 6);
            repeat (count) send_byte(char_t'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
            send_delimiter();
        end
        else if (pick < 50)
        begin
            send_byte(word_char(1'b1), 1'b0);
            count = $urandom_range(0, 7);
            repeat (count) send_byte(word_char(1'b0), 1'b0);
            send_delimiter();
        end
        else if (pick < 62)
        begin
            count = $urandom_range(1, 4);
            repeat (count) send_byte(blank_char(), 1'b0);
        end
        else if (pick < 70)
        begin
            // backslash comment up to the newline
            send_byte(CH_BACKSLASH, 1'b0);
            count = $urandom_range(0, 8);
            repeat (count)
            begin
                do
                    b = char_t'($urandom_range(0, 255));
                while (b == CH_NEWLINE);
                send_byte(b, 1'b0);
            end
            send_byte(CH_NEWLINE, 1'b0);
        end
        else if (pick < 80)
        begin
            // nested paren comment, closed to balance
            send_byte(CH_LPAREN, 1'b0);
            depth = 1;
            count = $urandom_range(0, 10);
            repeat (count)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        send_byte(CH_LPAREN, 1'b0);
                        depth++;
                    end
                    1:
                    begin
                        if (depth > 1)
                        begin
                            send_byte(CH_RPAREN, 1'b0);
                            depth--;
                        end
                    end
                    2:       send_byte(blank_char(), 1'b0);
                    default: send_byte(word_char(1'b0), 1'b0);
                endcase
            end
            send_run(CH_RPAREN, depth);
        end
        else if (pick < 87)
        begin
            // lone minus followed by a word byte or a delimiter
            send_byte(CH_MINUS, 1'b0);
            if ($urandom_range(0, 1))
                send_byte(word_char(1'b0), 1'b0);
            else
                send_byte(blank_char(), 1'b0);
        end
        else if (pick < 97)
        begin
            count = $urandom_range(1, 4);
            repeat (count) send_byte(char_t'($urandom_range(0, 255)), 1'b0);
        end
        else
            send_end();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // negative number cut by a letter, word, lone minus before a tab,
    // extreme byte values as word text, minus flushed by end of text
    task automatic test_token_kinds();
        send_text("-5x -\t");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_end();
        send_text("-");
        send_end();
    endtask

    // nested paren comment, number cut by a backslash comment, comment left
    // open at end of text, and counting that carries on after an end token
    task automatic test_comments();
        send_text("( a(b) )7\\ q\n");
        send_text("(x");
        send_end();
        send_text("1");
        send_end();
    endtask

    task automatic test_random_text();
        int   stop_at;
        int   next_shuffle;
        logic paused;
        stop_at      = items_sent + RANDOM_ITEMS;
        next_shuffle = items_sent;
        paused       = 1'b0;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_shuffle)
            begin
                gap_max      = pick_idle();
                stall_max    = pick_idle();
                next_shuffle = items_sent + $urandom_range(50, 150);
            end
            // one full stop halfway so the block runs dry mid-stream
            if (!paused && items_sent >= stop_at - RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
            send_random_segment();
        end
        send_end();
    endtask

    // a deep paren nest clamps the comment depth at its all-ones value;
    // unwinding from there closes the comment five ')' early
    task automatic test_counter_saturation();
        gap_max   = 0;
        stall_max = 3;
        send_run(CH_LPAREN, 260);
        send_run(CH_RPAREN, 255);
        send_text("8 \n");
        send_text("z");
        send_end();
    endtask

    initial
    begin : run_tests
        text_if.valid       <= 1'b0;
        text_if.text_byte   <= '0;
        text_if.end_of_text <= 1'b0;
        rst_n               <= 1'b0;

        lex_mode       = LEX_IDLE;
        paren_depth    = '0;
        cur_line       = POS_W'(1);
        cur_column     = POS_W'(1);
        cur_offset     = '0;
        tok_line       = POS_W'(1);
        tok_column     = POS_W'(1);
        tok_offset     = '0;
        tok_length     = '0;
        gap_max        = 11;
        stall_max      = 11;
        items_sent     = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_token_kinds();
        test_comments();
        test_random_text();
        wait_for_drain();
        test_counter_saturation();
        wait_for_drain();

        if (mismatch_count == 0)
            $display("stack_language_tokenizer_unit test passed");
        else
            $display("stack_language_tokenizer_unit test failed");
        $finish;
    end

endmodule
